// ===== design/dnd_pkg.sv =====
// dnd_pkg: shared types and constants for the dns name decompressor
// item, result, command and status structs used by the controller and datapath
// no dependencies
package dnd_pkg;

    localparam int POS_W    = 17;   // packet position, covers pointer targets and bounds
    localparam int LEN_W    = 9;    // decoded name length, 0..256
    localparam int NEED_W   = 10;   // length plus dot plus one label
    localparam int LABEL_W  = 6;    // label length field of a length byte
    localparam int OFFSET_W = 14;   // compression pointer offset

    localparam logic [7:0] PTR_MASK = 8'hc0;
    localparam logic [7:0] DOT_CHAR = 8'h2e;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BOUNDS = 2'd1;
    localparam logic [1:0] ST_LONG   = 2'd2;
    localparam logic [1:0] ST_HOPS   = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       restart;
        logic [8:0] start_offset;
        logic [9:0] limit_offset;
    } t_item;

    typedef struct packed {
        logic [63:0] name_chars;
        logic [3:0]  char_count;
        logic        last;
        logic [1:0]  status;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic       load_we;
        logic       init;
        logic       head_rd;
        logic       ptr_take;
        logic       ptr_jump;
        logic       lab_take;
        logic       copy_step;
        logic       out_init;
        logic       out_step;
        logic       emit_single;
        logic [1:0] code;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pos_oob;
        logic byte_zero;
        logic byte_ptr;
        logic ptr_oob;
        logic hops_max;
        logic lab_oob;
        logic too_long;
        logic len_zero;
        logic copy_done;
        logic out_done;
    } t_stat;

endpackage

// ===== design/dnd_ctrl.sv =====
// dnd_ctrl: sequencer for the name walk and the result output
// depends on dnd_pkg (t_cmd, t_stat, status and kind codes)
module dnd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_kind,
    input  dnd_pkg::t_stat i_stat,
    output logic          o_busy,
    output dnd_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HEAD = 3'd1;
    localparam logic [2:0] S_HDAT = 3'd2;
    localparam logic [2:0] S_PTR  = 3'd3;
    localparam logic [2:0] S_COPY = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_kind == dnd_pkg::KIND_DECODE) begin
                        o_cmd.init = 1'b1;
                        n_state    = S_HEAD;
                    end else begin
                        o_cmd.load_we = 1'b1;
                    end
                end
            end
            S_HEAD: begin
                if (i_stat.pos_oob) begin
                    o_cmd.emit_single = 1'b1;
                    o_cmd.code        = dnd_pkg::ST_BOUNDS;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.head_rd = 1'b1;
                    n_state       = S_HDAT;
                end
            end
            S_HDAT: begin
                if (i_stat.byte_zero) begin
                    if (i_stat.len_zero) begin
                        // root name: one empty word
                        o_cmd.emit_single = 1'b1;
                        o_cmd.code        = dnd_pkg::ST_OK;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.out_init = 1'b1;
                        n_state        = S_OUT;
                    end
                end else if (i_stat.byte_ptr) begin
                    if (i_stat.ptr_oob) begin
                        o_cmd.emit_single = 1'b1;
                        o_cmd.code        = dnd_pkg::ST_BOUNDS;
                        n_state           = S_IDLE;
                    end else if (i_stat.hops_max) begin
                        o_cmd.emit_single = 1'b1;
                        o_cmd.code        = dnd_pkg::ST_HOPS;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.ptr_take = 1'b1;
                        n_state        = S_PTR;
                    end
                end else if (i_stat.lab_oob) begin
                    o_cmd.emit_single = 1'b1;
                    o_cmd.code        = dnd_pkg::ST_BOUNDS;
                    n_state           = S_IDLE;
                end else if (i_stat.too_long) begin
                    o_cmd.emit_single = 1'b1;
                    o_cmd.code        = dnd_pkg::ST_LONG;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.lab_take = 1'b1;
                    n_state        = S_COPY;
                end
            end
            S_PTR: begin
                o_cmd.ptr_jump = 1'b1;
                n_state        = S_HEAD;
            end
            S_COPY: begin
                if (i_stat.copy_done) begin
                    n_state = S_HEAD;
                end else begin
                    o_cmd.copy_step = 1'b1;
                end
            end
            S_OUT: begin
                o_cmd.out_step = 1'b1;
                if (i_stat.out_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== design/dnd_dpath.sv =====
// dnd_dpath: packet store, name buffer, walk registers and result register
// depends on dnd_pkg (t_item, t_result, t_cmd, t_stat, constants)
module dnd_dpath #(
    parameter int PACKET_BYTES = 512,
    parameter int NAME_BYTES   = 256,
    parameter int MAX_HOPS     = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    input  dnd_pkg::t_item   i_item,
    input  dnd_pkg::t_cmd    i_cmd,
    output dnd_pkg::t_stat   o_stat,
    output logic             o_strobe,
    output dnd_pkg::t_result o_result
);

    localparam int PA_W   = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam int FILL_W = $clog2(PACKET_BYTES + 1);
    localparam int NB_AW  = $clog2(NAME_BYTES);
    localparam int HOP_W  = $clog2(MAX_HOPS + 1);
    localparam int POS_W  = dnd_pkg::POS_W;
    localparam int LEN_W  = dnd_pkg::LEN_W;
    localparam int NEED_W = dnd_pkg::NEED_W;
    localparam int LAB_W  = dnd_pkg::LABEL_W;

    logic [7:0]        r_max_len;
    logic [FILL_W-1:0] r_fill;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_bound;
    logic [LEN_W-1:0]  r_limit;
    logic [LEN_W-1:0]  r_len;
    logic [HOP_W-1:0]  r_hops;
    logic [LAB_W-1:0]  r_ptr_hi;
    logic [LAB_W-1:0]  r_cnt;
    logic              r_wpend;
    logic [LEN_W-1:0]  r_oidx;
    logic              r_opend;
    logic [LEN_W-1:0]  r_recv;
    logic [2:0]        r_k;
    logic [63:0]       r_word;
    logic              r_strobe;
    dnd_pkg::t_result  r_result;

    logic [7:0] r_pkt_mem [PACKET_BYTES];
    logic [7:0] r_pkt_q;
    logic [7:0] r_nb_mem [NAME_BYTES];
    logic [7:0] r_nb_q;

    logic              pkt_we;
    logic [PA_W-1:0]   pkt_waddr;
    logic              pkt_re;
    logic [PA_W-1:0]   pkt_raddr;
    logic              nb_we;
    logic [7:0]        nb_wdata;
    logic              nb_re;
    logic              fill_room;
    logic [POS_W-1:0]  n_bound;
    logic [LEN_W-1:0]  n_limit;
    logic [NEED_W-1:0] need;
    logic              final_byte;
    logic [63:0]       n_word;
    logic              word_full;

    // packet store
    assign fill_room = (r_fill < FILL_W'(PACKET_BYTES));
    assign pkt_we    = i_cmd.load_we && (i_item.restart || fill_room);
    assign pkt_waddr = i_item.restart ? '0 : r_fill[PA_W-1:0];
    assign pkt_re    = i_cmd.head_rd || i_cmd.ptr_take || (i_cmd.copy_step && (r_cnt != '0));
    assign pkt_raddr = i_cmd.ptr_take ? PA_W'(r_pos + POS_W'(1)) : r_pos[PA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (pkt_we) begin
            r_pkt_mem[pkt_waddr] <= i_item.data_byte;
        end
        if (pkt_re) begin
            r_pkt_q <= r_pkt_mem[pkt_raddr];
        end
    end

    // name buffer
    assign nb_we    = (i_cmd.lab_take && (r_len != '0)) || (i_cmd.copy_step && r_wpend);
    assign nb_wdata = i_cmd.lab_take ? dnd_pkg::DOT_CHAR : r_pkt_q;
    assign nb_re    = i_cmd.out_step && (r_oidx < r_len);

    always_ff @(posedge i_clk) begin
        if (nb_we) begin
            r_nb_mem[r_len[NB_AW-1:0]] <= nb_wdata;
        end
        if (nb_re) begin
            r_nb_q <= r_nb_mem[r_oidx[NB_AW-1:0]];
        end
    end

    // clamped bound and length limit for a new request
    always_comb begin
        if (POS_W'(i_item.limit_offset) > POS_W'(PACKET_BYTES)) begin
            n_bound = POS_W'(PACKET_BYTES);
        end else begin
            n_bound = POS_W'(i_item.limit_offset);
        end
        if (LEN_W'(r_max_len) > LEN_W'(NAME_BYTES)) begin
            n_limit = LEN_W'(NAME_BYTES);
        end else begin
            n_limit = LEN_W'(r_max_len);
        end
    end

    assign need = NEED_W'(r_len) + ((r_len != '0) ? NEED_W'(1) : NEED_W'(0))
                + NEED_W'(r_pkt_q[LAB_W-1:0]);

    assign o_stat.pos_oob   = (r_pos >= r_bound);
    assign o_stat.byte_zero = (r_pkt_q == 8'd0);
    assign o_stat.byte_ptr  = ((r_pkt_q & dnd_pkg::PTR_MASK) != 8'd0);
    assign o_stat.ptr_oob   = ((r_pos + POS_W'(1)) >= r_bound);
    assign o_stat.hops_max  = (r_hops >= HOP_W'(MAX_HOPS));
    assign o_stat.lab_oob   = ((r_pos + POS_W'(r_pkt_q)) >= r_bound);
    assign o_stat.too_long  = (need > NEED_W'(r_limit));
    assign o_stat.len_zero  = (r_len == '0);
    assign o_stat.copy_done = (r_cnt == '0) && !r_wpend;
    assign o_stat.out_done  = r_opend && final_byte;

    // output word assembly
    assign final_byte = ((r_recv + LEN_W'(1)) == r_len);
    assign n_word     = r_word | (64'(r_nb_q) << {r_k, 3'b000});
    assign word_full  = (r_k == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 8'd255;
            r_fill    <= '0;
            r_strobe  <= 1'b0;
            r_wpend   <= 1'b0;
            r_opend   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end

            if (i_cmd.load_we) begin
                if (i_item.restart) begin
                    r_fill <= FILL_W'(1);
                end else if (fill_room) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end

            if (i_cmd.init) begin
                r_pos   <= POS_W'(i_item.start_offset);
                r_bound <= n_bound;
                r_limit <= n_limit;
                r_len   <= '0;
                r_hops  <= '0;
            end

            if (i_cmd.ptr_take) begin
                r_hops   <= r_hops + HOP_W'(1);
                r_ptr_hi <= r_pkt_q[LAB_W-1:0];
            end

            if (i_cmd.ptr_jump) begin
                r_pos <= POS_W'({r_ptr_hi, r_pkt_q});
            end

            if (i_cmd.lab_take) begin
                r_pos   <= r_pos + POS_W'(1);
                r_cnt   <= r_pkt_q[LAB_W-1:0];
                r_wpend <= 1'b0;
            end

            if (i_cmd.copy_step) begin
                if (r_cnt != '0) begin
                    r_pos <= r_pos + POS_W'(1);
                    r_cnt <= r_cnt - LAB_W'(1);
                end
                r_wpend <= (r_cnt != '0);
            end

            if (nb_we) begin
                r_len <= r_len + LEN_W'(1);
            end

            if (i_cmd.out_init) begin
                r_oidx  <= '0;
                r_opend <= 1'b0;
                r_recv  <= '0;
                r_k     <= '0;
                r_word  <= '0;
            end

            r_strobe <= 1'b0;
            if (i_cmd.emit_single) begin
                r_strobe            <= 1'b1;
                r_result.name_chars <= '0;
                r_result.char_count <= '0;
                r_result.last       <= 1'b1;
                r_result.status     <= i_cmd.code;
            end

            if (i_cmd.out_step) begin
                if (nb_re) begin
                    r_oidx <= r_oidx + LEN_W'(1);
                end
                r_opend <= nb_re;
                if (r_opend) begin
                    r_recv <= r_recv + LEN_W'(1);
                    if (word_full || final_byte) begin
                        r_strobe            <= 1'b1;
                        r_result.name_chars <= n_word;
                        r_result.char_count <= 4'(r_k) + 4'd1;
                        r_result.last       <= final_byte;
                        r_result.status     <= dnd_pkg::ST_OK;
                        r_word              <= '0;
                        r_k                 <= '0;
                    end else begin
                        r_word <= n_word;
                        r_k    <= r_k + 3'd1;
                    end
                end
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== design/dns_name_decompress_core.sv =====
// dns_name_decompress_core: top level of the dns name decompressor
// instantiates dnd_ctrl and dnd_dpath, uses dnd_pkg types
//
// A load transfer (kind 0) writes one packet byte at the fill position (at
// zero on a restart); busy stays low, so bytes can stream in every cycle. A
// decode transfer (kind 1) raises busy until its last result word is out.
// The walk reads the packet store through its single registered read port:
// each length byte is read in the head state and checked in the data state,
// a pointer adds a jump state once its second byte is read, and the
// characters of a label are then copied into the name buffer in the copy
// state. A decoded name streams out of the name buffer in words of up to eight
// characters, the last word flagged. An error or an empty name gives a
// single word right after it is found. Results carry a one-cycle strobe and
// cannot be held off, so the receiver must take every word when it appears.
module dns_name_decompress_core #(
    parameter int PACKET_BYTES = 512,
    parameter int NAME_BYTES   = 256,
    parameter int MAX_HOPS     = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request transfer
    input  logic             start,
    output logic             busy,
    input  dnd_pkg::t_item   i_item,
    // max_name_length register
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    // result words
    output logic             o_strobe,
    output dnd_pkg::t_result o_result
);

    dnd_pkg::t_cmd  cmd;
    dnd_pkg::t_stat stat;

    // sequencer: walk, pointer hops, label copy, output phase
    dnd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_item.kind),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // stores, bounds checks and the registered result word
    dnd_dpath #(
        .PACKET_BYTES (PACKET_BYTES),
        .NAME_BYTES   (NAME_BYTES),
        .MAX_HOPS     (MAX_HOPS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

// ===== design/dnd_checker.sv =====
// dnd_checker: port-level checks on the result words of the decompressor
// depends on dnd_pkg; bound to dns_name_decompress_core below
module dnd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input dnd_pkg::t_item   i_item,
    input logic             o_strobe,
    input dnd_pkg::t_result o_result
);

    // error words are empty and final
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status != dnd_pkg::ST_OK)
        |-> o_result.last && (o_result.char_count == 4'd0) && (o_result.name_chars == 64'd0))
        else $error("error word not empty or not last");

    // a word before the last is full and ok
    a_mid_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last
        |-> (o_result.char_count == 4'd8) && (o_result.status == dnd_pkg::ST_OK))
        else $error("non-final word not full");

    // busy drops exactly with the last word
    a_busy_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (busy == !o_result.last))
        else $error("busy does not match last flag");

    // a load transfer leaves the block idle and produces no word
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.kind == dnd_pkg::KIND_LOAD) |=> !busy && !o_strobe)
        else $error("load transfer started a walk");

endmodule

bind dns_name_decompress_core dnd_checker u_dnd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for dns_name_decompress_core
// depends on dnd_pkg for the item/result structs and the kind and status codes
module testbench;

    localparam int PACKET_BYTES = 512;
    localparam int NAME_BYTES   = 256;
    localparam int MAX_HOPS     = 16;
    // a long walk plus a 32-word name stays far below this
    localparam int STALL_LIMIT  = 20000;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             busy;
    dnd_pkg::t_item   i_item     = '0;
    logic             i_cfg_we   = 1'b0;
    logic       [7:0] i_cfg_data = 8'd0;
    logic             o_strobe;
    dnd_pkg::t_result o_result;

    dns_name_decompress_core #(
        .PACKET_BYTES(PACKET_BYTES),
        .NAME_BYTES  (NAME_BYTES),
        .MAX_HOPS    (MAX_HOPS)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: our own copy of the packet store, fill position,
    // name buffer and the max_name_length register
    // ------------------------------------------------------------------
    logic [7:0]  pkt_mem [PACKET_BYTES];
    logic [7:0]  name_buf [NAME_BYTES];
    int unsigned fill_pos;
    logic [7:0]  max_len_reg;

    dnd_pkg::t_item   pending_q[$];        // transfers waiting to be driven
    dnd_pkg::t_result expected_words[$];   // name words the block still owes us
    dnd_pkg::t_result want;

    int errors       = 0;
    int stall_cycles = 0;
    int idle_pct     = 0;
    int n_queued     = 0;

    // generator side: packet image being built, offsets of names inside it,
    // and how far the store has been filled (reads past that are never caused)
    logic [7:0]  gen_bytes[$];
    int unsigned gen_names[$];
    int unsigned gen_fill    = 0;
    int unsigned gen_maxfill = 0;

    // walk labels and pointers from 'from', building the dotted name
    function automatic logic [1:0] decode_name(input int unsigned from,
                                               input int unsigned bound,
                                               input int unsigned lim,
                                               output int unsigned len);
        int unsigned pos, hops, lab, need;
        logic [7:0] b;
        pos  = from;
        len  = 0;
        hops = 0;
        while (1) begin
            if (pos >= bound) return dnd_pkg::ST_BOUNDS;
            b = pkt_mem[pos];
            if (b == 8'h00) return dnd_pkg::ST_OK;
            // either top bit set means pointer, reserved forms included
            if ((b & dnd_pkg::PTR_MASK) != 8'h00) begin
                if (pos + 1 >= bound) return dnd_pkg::ST_BOUNDS;
                hops++;
                if (hops > MAX_HOPS) return dnd_pkg::ST_HOPS;
                pos = {b[5:0], pkt_mem[pos + 1]};
                continue;
            end
            lab = b;
            if (pos + lab >= bound) return dnd_pkg::ST_BOUNDS;
            need = len + ((len != 0) ? 1 : 0) + lab;
            if (need > lim) return dnd_pkg::ST_LONG;
            if (len != 0) begin
                name_buf[len] = dnd_pkg::DOT_CHAR;
                len++;
            end
            for (int i = 0; i < lab; i++) begin
                name_buf[len] = pkt_mem[pos + 1 + i];
                len++;
            end
            pos += lab + 1;
        end
        return dnd_pkg::ST_OK;
    endfunction

    // apply one accepted transfer to the predictor, queueing the words it causes
    function automatic void apply_transfer(input dnd_pkg::t_item it);
        int unsigned bound, lim, len, n_words, cnt;
        logic [1:0] code;
        dnd_pkg::t_result w;
        if (it.kind == dnd_pkg::KIND_LOAD) begin
            if (it.restart) fill_pos = 0;
            // a full store drops the byte
            if (fill_pos < PACKET_BYTES) begin
                pkt_mem[fill_pos] = it.data_byte;
                fill_pos++;
            end
            return;
        end
        bound = it.limit_offset;
        if (bound > PACKET_BYTES) bound = PACKET_BYTES;
        lim = max_len_reg;
        if (lim > NAME_BYTES) lim = NAME_BYTES;
        code = decode_name(it.start_offset, bound, lim, len);
        if (code != dnd_pkg::ST_OK) begin
            // any error: one empty word carrying the status
            w        = '0;
            w.last   = 1'b1;
            w.status = code;
            expected_words.push_back(w);
            return;
        end
        // root name still gives one (empty) word
        n_words = (len + 7) / 8;
        if (n_words == 0) n_words = 1;
        for (int k = 0; k < n_words; k++) begin
            w   = '0;
            cnt = (len > k * 8) ? len - k * 8 : 0;
            if (cnt > 8) cnt = 8;
            for (int j = 0; j < cnt; j++) w.name_chars[8 * j +: 8] = name_buf[8 * k + j];
            w.char_count = cnt[3:0];
            w.last       = (k == n_words - 1);
            w.status     = dnd_pkg::ST_OK;
            expected_words.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------
    // driver: takes the next pending item when nothing is held, idling at
    // random; an item stays presented while busy blocks the transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start       <= 1'b0;
            fill_pos    = 0;
            max_len_reg = 8'd255;
        end else begin
            if (i_cfg_we) max_len_reg = i_cfg_data;
            if (start && !busy) apply_transfer(i_item);
            if (start && busy) begin
                // held, start stays high
            end else if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_item <= pending_q.pop_front();
                start  <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every strobed word must match the oldest expected word
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_words.size() == 0) begin
                $error("result word with none expected: chars %h count %0d last %0d status %0d",
                       o_result.name_chars, o_result.char_count, o_result.last, o_result.status);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (o_result.name_chars !== want.name_chars) begin
                    $error("name_chars: expected %h, got %h", want.name_chars,
                           o_result.name_chars);
                    errors++;
                end
                if (o_result.char_count !== want.char_count) begin
                    $error("char_count: expected %0d, got %0d", want.char_count,
                           o_result.char_count);
                    errors++;
                end
                if (o_result.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_result.last);
                    errors++;
                end
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no transfer in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_load(input logic [7:0] b, input logic first);
        dnd_pkg::t_item it;
        it.kind         = dnd_pkg::KIND_LOAD;
        it.data_byte    = b;
        it.restart      = first;
        it.start_offset = 9'($urandom_range(511));
        it.limit_offset = 10'($urandom_range(1023));
        pending_q.push_back(it);
        if (first) gen_fill = 0;
        if (gen_fill < PACKET_BYTES) gen_fill++;
        if (gen_fill > gen_maxfill) gen_maxfill = gen_fill;
        n_queued++;
    endfunction

    // decode request with the bound taken as given
    function automatic void push_request(input int unsigned from, input int unsigned lim);
        dnd_pkg::t_item it;
        it.kind         = dnd_pkg::KIND_DECODE;
        it.data_byte    = 8'($urandom_range(255));
        it.restart      = 1'($urandom_range(1));
        it.start_offset = 9'(from);
        it.limit_offset = 10'(lim);
        pending_q.push_back(it);
        n_queued++;
    endfunction

    // bound never reaches past what has been loaded so far
    function automatic void push_decode(input int unsigned from, input int unsigned lim);
        if (gen_maxfill < PACKET_BYTES && lim > gen_maxfill) lim = gen_maxfill;
        push_request(from, lim);
    endfunction

    function automatic void send_packet();
        foreach (gen_bytes[i]) push_load(gen_bytes[i], i == 0);
    endfunction

    // mostly letters, sometimes any byte value
    function automatic logic [7:0] rand_char();
        if ($urandom_range(4) == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(8'h61, 8'h7a));
    endfunction

    function automatic void add_label(input int unsigned n);
        gen_bytes.push_back(8'(n));
        repeat (n) gen_bytes.push_back(rand_char());
    endfunction

    function automatic void add_pointer(input int unsigned target, input logic [7:0] form);
        logic [13:0] t;
        t = 14'(target);
        gen_bytes.push_back(form | {2'b00, t[13:8]});
        gen_bytes.push_back(t[7:0]);
    endfunction

    // labels, then a terminator: zero byte, back pointer, or a wild pointer
    function automatic void add_name();
        int unsigned at, pick;
        logic [7:0] form;
        at = gen_bytes.size();
        repeat ($urandom_range(0, 3))
            add_label(($urandom_range(9) == 0) ? $urandom_range(9, 63) : $urandom_range(1, 8));
        case ($urandom_range(7))
            0:       form = 8'h40;
            1:       form = 8'h80;
            default: form = 8'hc0;
        endcase
        pick = $urandom_range(9);
        if (pick == 0)
            add_pointer($urandom_range(16383), 8'hc0);
        else if (pick < 6 && gen_names.size() != 0)
            add_pointer(gen_names[$urandom_range(gen_names.size() - 1)], form);
        else
            gen_bytes.push_back(8'h00);
        gen_names.push_back(at);
    endfunction

    // pointer to itself, never terminates
    function automatic void add_loop();
        int unsigned at;
        at = gen_bytes.size();
        add_pointer(at, 8'hc0);
        gen_names.push_back(at);
    endfunction

    // short name behind exactly MAX_HOPS pointers, then one hop too many
    function automatic void add_chain(output int unsigned ok_at, output int unsigned bad_at);
        int unsigned prev, at;
        prev = gen_bytes.size();
        add_label($urandom_range(1, 6));
        gen_bytes.push_back(8'h00);
        repeat (MAX_HOPS) begin
            at = gen_bytes.size();
            add_pointer(prev, 8'hc0);
            prev = at;
        end
        ok_at  = prev;
        bad_at = gen_bytes.size();
        add_pointer(prev, 8'hc0);
        gen_names.push_back(ok_at);
        gen_names.push_back(bad_at);
    endfunction

    // well-formed requests mostly, some cut short, some at random offsets
    function automatic void decode_mix(input int n);
        int unsigned pick;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 60)
                push_decode(gen_names[$urandom_range(gen_names.size() - 1)], gen_bytes.size());
            else if (pick < 80)
                push_decode(gen_names[$urandom_range(gen_names.size() - 1)],
                            $urandom_range(gen_bytes.size()));
            else
                push_decode($urandom_range(511), $urandom_range(1023));
        end
    endfunction

    // sender holds off until the block is idle and every word is back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || start || busy || expected_words.size() != 0);
    endtask

    // register write only once the block is idle; loads leave no word behind,
    // so give the last one time to land first
    task automatic write_max_len(input logic [7:0] v);
        wait_drained();
        repeat (20) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // decodes over the loaded image, with a full drain halfway
    task automatic run_phase(input logic [7:0] max_len, input int pct, input int n_items);
        write_max_len(max_len);
        idle_pct = pct;
        decode_mix(n_items / 2);
        wait_drained();
        decode_mix(n_items - n_items / 2);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned big_at, wbig_at, chain_ok, chain_bad;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed packet:
        //   0 root, 1 "a.bc", 7 "x" + reserved 0x40 pointer to 1,
        //   11 reserved 0x80 pointer to itself, 13 pointer far past the bound
        idle_pct  = 0;
        gen_bytes = '{8'h00, 8'h01, 8'h61, 8'h02, 8'h62, 8'h63, 8'h00, 8'h01, 8'h78,
                      8'h40, 8'h01, 8'h80, 8'h0b, 8'hff, 8'hff};
        send_packet();
        push_decode(0, 15);     // root name, empty ok word
        push_decode(1, 15);
        push_decode(7, 15);     // pointer ends the name
        push_decode(11, 15);    // hop limit
        push_decode(13, 15);    // target out of bounds
        push_decode(1, 4);      // label data past the bound
        push_decode(7, 10);     // pointer second byte past the bound
        push_decode(511, 15);   // start past the bound
        push_decode(0, 0);      // nothing readable at all

        // zero limit: every non-empty name too long, root still fine
        write_max_len(8'd0);
        push_decode(1, 15);
        push_decode(0, 15);
        // limit equal to the name length passes, longer names fail
        write_max_len(8'd4);
        push_decode(1, 15);
        push_decode(7, 15);
        write_max_len(8'd1);
        push_decode(7, 15);

        // larger packet under sender idling: hop chain, a self loop, a
        // 191-char name (24 words), and a name placed above offset 255
        write_max_len(8'd255);
        idle_pct = 45;
        gen_bytes.delete();
        gen_names.delete();
        repeat (12) gen_bytes.push_back(8'($urandom_range(255)));
        add_chain(chain_ok, chain_bad);
        add_loop();
        big_at = gen_bytes.size();
        repeat (3) add_label(63);
        gen_bytes.push_back(8'h00);
        gen_names.push_back(big_at);
        repeat (2) add_name();
        while (gen_bytes.size() < 256) gen_bytes.push_back(8'($urandom_range(255)));
        wbig_at = gen_bytes.size();
        add_label(1);
        add_pointer(big_at, 8'hc0);
        gen_names.push_back(wbig_at);
        send_packet();
        push_decode(big_at, 512);
        push_request(big_at, 700);     // bound clamps to the store size
        push_decode(wbig_at, 512);     // 193 chars through a pointer
        push_decode(chain_ok, 512);
        push_decode(chain_bad, 512);
        push_decode(chain_ok, chain_ok + 1);
        push_decode(511, 512);
        decode_mix(6);

        // random phases across register settings and sender idling
        run_phase(8'd20, 36, 12);
        run_phase(8'd1, 0, 8);
        run_phase(8'($urandom_range(2, 254)), 45, 12);

        wait_drained();
        repeat (50) @(negedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d result words never arrived", expected_words.size());
            errors++;
        end
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
